/* rtl/core/lbp_pkg.sv */
package lbp_pkg;

  localparam int unsigned MaxFieldBits = 64;
  localparam int unsigned RangeMaxBits = 32;
  localparam int unsigned JobDepth     = 4;
  localparam int unsigned JobAw        = $clog2(JobDepth);

  typedef enum logic [2:0] {
    ModeBit   = 3'd0,
    ModeRaw   = 3'd1,
    ModeRange = 3'd2,
    ModeSoft  = 3'd3,
    ModeFlush = 3'd4
  } mode_e;

  // classified field, before merging with the pending partial byte
  typedef struct packed {
    logic [63:0] bits;
    logic [6:0]  len;
    logic        err;
    logic        flush;
  } field_t;

  // one packed input: up to eight finished bytes and the status they carry
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        err;
    logic [31:0] bits_written;
  } job_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        range_error;
    logic [31:0] bits_written;
  } res_t;

  function automatic logic [63:0] low_mask64(logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'(MaxFieldBits)) begin
      m = '1;
    end else begin
      m = (64'd1 << n[5:0]) - 64'd1;
    end
    return m;
  endfunction

  function automatic logic [31:0] low_mask32(logic [5:0] n);
    logic [31:0] m;
    if (n >= 6'(RangeMaxBits)) begin
      m = '1;
    end else begin
      m = (32'd1 << n[4:0]) - 32'd1;
    end
    return m;
  endfunction

endpackage

/* rtl/core/lsb_first_bit_packer.sv */
// Channel   Handshake             Fields
// input     push / full           mode_i value_i bit_count_i min_value_i max_value_i range_bits_i
// result    empty / pop           byte_valid_o out_byte_o last_of_run_o range_error_o
//                                 bits_written_o
//
// One word is taken per cycle while full is low; the front classifies it, then
// merges it with the pending partial byte and queues the finished bytes (four-entry
// job queue). The back sends one result word per cycle while results are popped:
// one for each finished byte of a word, or one with byte_valid low for a word that
// fills none. Sustained rate is one input per cycle while results are popped and
// each input yields at most one result. Reset clears the pending bits and the stream bit count.
module lsb_first_bit_packer import lbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode_i,
  input  logic [63:0] value_i,
  input  logic [6:0]  bit_count_i,
  input  logic [31:0] min_value_i,
  input  logic [31:0] max_value_i,
  input  logic [5:0]  range_bits_i,
  output logic        empty,
  input  logic        pop,
  output logic        byte_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        range_error_o,
  output logic [31:0] bits_written_o
);

  job_t job_in, job_out;
  logic job_push, job_full, job_pop, job_empty;
  logic res_vld;
  res_t res;

  lbp_front u_front (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .full_o       (full),
    .mode_i,
    .value_i,
    .bit_count_i,
    .min_value_i,
    .max_value_i,
    .range_bits_i,
    .job_push_o   (job_push),
    .job_full_i   (job_full),
    .job_o        (job_in)
  );

  lbp_job_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (job_push),
    .full_o  (job_full),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .rdata_o (job_out)
  );

  lbp_back u_back (
    .clk_i,
    .rst_ni,
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_vld_o   (res_vld),
    .res_take_i  (pop),
    .res_o       (res)
  );

  assign empty          = !res_vld;
  assign byte_valid_o   = res.byte_valid;
  assign out_byte_o     = res.out_byte;
  assign last_of_run_o  = res.last_of_run;
  assign range_error_o  = res.range_error;
  assign bits_written_o = res.bits_written;

endmodule

/* rtl/core/lbp_front.sv */
module lbp_front import lbp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [2:0]   mode_i,
  input  logic [63:0]  value_i,
  input  logic [6:0]   bit_count_i,
  input  logic [31:0]  min_value_i,
  input  logic [31:0]  max_value_i,
  input  logic [5:0]   range_bits_i,
  output logic         job_push_o,
  input  logic         job_full_i,
  output job_t         job_o
);

  field_t      fld_d, fld_q;
  logic        vld_q;
  logic        adv;

  logic [6:0]  pend_bits_q, pend_bits_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;
  logic [31:0] pos_q, pos_d;

  logic signed [63:0] sval, minv, maxv;
  logic [6:0]  bcount;
  logic [5:0]  rbits;
  logic [31:0] clamped;
  logic [31:0] rel;

  logic [70:0] merged;
  logic [6:0]  total;
  logic [6:0]  adv_bits;
  logic [32:0] pos_sum;

  assign sval = $signed(value_i);
  assign minv = $signed({{32{min_value_i[31]}}, min_value_i});
  assign maxv = $signed({{32{max_value_i[31]}}, max_value_i});
  assign bcount = (bit_count_i > 7'(MaxFieldBits)) ? 7'(MaxFieldBits) : bit_count_i;
  assign rbits  = (range_bits_i > 6'(RangeMaxBits)) ? 6'(RangeMaxBits) : range_bits_i;

  always_comb begin
    if (sval < minv) begin
      clamped = min_value_i;
    end else if (sval > maxv) begin
      clamped = max_value_i;
    end else begin
      clamped = value_i[31:0];
    end
    rel = clamped - min_value_i;
  end

  // classify the field: its bits, LSB first, and its length
  always_comb begin
    fld_d = '0;
    unique case (mode_i)
      ModeBit: begin
        fld_d.bits = {63'd0, value_i[0]};
        fld_d.len  = 7'd1;
      end
      ModeRaw: begin
        fld_d.bits = value_i & low_mask64(bcount);
        fld_d.len  = bcount;
      end
      ModeRange: begin
        fld_d.bits = {32'd0, rel & low_mask32(rbits)};
        fld_d.len  = {1'b0, rbits};
        fld_d.err  = (sval < minv) || (sval > maxv);
      end
      ModeSoft: begin
        if (sval <= maxv) begin
          fld_d.bits = {31'd0,
                        (value_i[63] ? 32'd0 : value_i[31:0]) & low_mask32(rbits),
                        1'b1};
          fld_d.len  = 7'({1'b0, rbits}) + 7'd1;
          fld_d.err  = value_i[63];
        end else begin
          fld_d.bits = {31'd0, value_i[31:0], 1'b0};
          fld_d.len  = 7'd33;
        end
      end
      ModeFlush: begin
        fld_d.flush = 1'b1;
      end
      default: begin
        fld_d = '0;
      end
    endcase
  end

  assign job_push_o = vld_q && !job_full_i;
  assign adv        = !vld_q || !job_full_i;
  assign full_o     = !adv;

  // merge with the pending partial byte, or on a flush emit that byte zero-padded
  always_comb begin
    merged      = ({7'd0, fld_q.bits} << pend_cnt_q) | {64'd0, pend_bits_q};
    total       = 7'({4'd0, pend_cnt_q}) + fld_q.len;
    job_o.err   = fld_q.err;
    if (fld_q.flush) begin
      job_o.data   = {57'd0, pend_bits_q};
      job_o.nbytes = (pend_cnt_q != 3'd0) ? 4'd1 : 4'd0;
      adv_bits     = (pend_cnt_q != 3'd0) ? (7'd8 - {4'd0, pend_cnt_q}) : 7'd0;
      pend_bits_d  = '0;
      pend_cnt_d   = '0;
    end else begin
      job_o.data   = merged[63:0];
      job_o.nbytes = total[6:3];
      adv_bits     = fld_q.len;
      pend_bits_d  = 7'(merged >> {total[6:3], 3'b000});
      pend_cnt_d   = total[2:0];
    end
    pos_sum            = {1'b0, pos_q} + {26'd0, adv_bits};
    // hold at all ones once the count overflows
    pos_d              = pos_sum[32] ? '1 : pos_sum[31:0];
    job_o.bits_written = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      pos_q       <= '0;
    end else begin
      if (adv) begin
        vld_q <= push_i;
      end
      if (job_push_o) begin
        pend_bits_q <= pend_bits_d;
        pend_cnt_q  <= pend_cnt_d;
        pos_q       <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && push_i) begin
      fld_q <= fld_d;
    end
  end

endmodule

/* rtl/core/lbp_job_fifo.sv */
module lbp_job_fifo import lbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  job_t wdata_i,
  input  logic pop_i,
  output logic empty_o,
  output job_t rdata_o
);

  job_t             mem [JobDepth];
  logic [JobAw-1:0] wr_q, rd_q;
  logic [JobAw:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (JobAw+1)'(JobDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + JobAw'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + JobAw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (JobAw+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (JobAw+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/core/lbp_back.sv */
module lbp_back import lbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_empty_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic res_vld_o,
  input  logic res_take_i,
  output res_t res_o
);

  logic       vld_q;
  res_t       res_q;
  logic [2:0] idx_q;
  logic       load;
  logic       last;
  logic       has_byte;

  assign has_byte  = (job_i.nbytes != 4'd0);
  assign last      = !has_byte || (({1'b0, idx_q} + 4'd1) == job_i.nbytes);
  assign load      = !job_empty_i && (!vld_q || res_take_i);
  assign job_pop_o = load && last;
  assign res_vld_o = vld_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        // advance through the job's bytes, drop back to the first on the last
        idx_q <= last ? 3'd0 : idx_q + 3'd1;
      end else if (res_take_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q.byte_valid   <= has_byte;
      res_q.out_byte     <= has_byte ? job_i.data[{idx_q, 3'b000} +: 8] : 8'd0;
      res_q.last_of_run  <= last;
      res_q.range_error  <= job_i.err;
      res_q.bits_written <= job_i.bits_written;
    end
  end

endmodule
